[rtl/sfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sensor frame deframer: frame header bytes,
// status codes, selector codes and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame header and selector limit
  localparam logic [7:0] SYNC0      = 8'hFF;
  localparam logic [7:0] SYNC1      = 8'hFC;
  localparam logic [7:0] SEL_LIMIT  = 8'hF1;

  // number of payload bytes kept for word extraction
  localparam int unsigned HeadDepth = 8;
  localparam int unsigned HeadIdxW  = $clog2(HeadDepth);
  localparam int unsigned HeadCntW  = HeadIdxW + 1;

  // selector codes
  localparam logic [7:0] SEL_NONE     = 8'd0;
  localparam logic [7:0] SEL_SPEED    = 8'd5;
  localparam logic [7:0] SEL_DISTANCE = 8'd6;
  localparam logic [7:0] SEL_PRESSURE = 8'd7;
  localparam logic [7:0] SEL_SPD_DIST = 8'd8;
  localparam logic [7:0] SEL_CUR_PRES = 8'd9;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CHECKSUM  = 2'd1,
    STATUS_UNKNOWN   = 2'd2,
    STATUS_SHORT     = 2'd3
  } status_e;

  typedef struct packed {
    status_e     frame_status;
    logic [7:0]  selector;
    logic        speed_valid;
    logic [31:0] speed_bits;
    logic        distance_valid;
    logic [31:0] distance_bits;
    logic        distance_in_hundredths;
    logic        pressure_valid;
    logic [31:0] pressure_bits;
    logic        current_valid;
    logic [31:0] current_bits;
  } result_t;

endpackage

[rtl/sfd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parser
// Byte-wise frame parser: tracks header, selector, length, payload and
// checksum, keeps the first payload bytes and builds the frame result.
// ----------------------------------------------------------------------------
module sfd_parser #(
  parameter int unsigned MAX_PAYLOAD = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output logic            res_valid_o,
  output sfd_pkg::result_t res_o
);

  localparam int unsigned LenW = 9;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SYNC0   = 3'd1,
    PH_SYNC1   = 3'd2,
    PH_SEL     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [7:0]                      left_q, left_d;
  logic [sfd_pkg::HeadCntW-1:0]    count_q, count_d;
  logic [7:0]                      sum_q, sum_d;
  logic [7:0]                      sel_q, sel_d;
  logic [7:0]                      head_q [sfd_pkg::HeadDepth];
  logic                            head_we;
  logic                            len_ok;
  logic [7:0]                      sum_add;

  assign len_ok  = {1'b0, rx_byte_i} < LenW'(MAX_PAYLOAD);
  assign sum_add = sum_q + rx_byte_i;

  // next state of the parser
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    count_d = count_q;
    sum_d   = sum_q;
    sel_d   = sel_q;
    head_we = 1'b0;
    if (phase_q == PH_IDLE && rx_byte_i == sfd_pkg::SYNC0) begin
      phase_d = PH_SYNC0;
      sum_d   = rx_byte_i;
    end else if (phase_q == PH_SYNC0 && rx_byte_i == sfd_pkg::SYNC1) begin
      phase_d = PH_SYNC1;
      sum_d   = sum_add;
    end else if (phase_q == PH_SYNC1 && rx_byte_i < sfd_pkg::SEL_LIMIT) begin
      phase_d = PH_SEL;
      sel_d   = rx_byte_i;
      sum_d   = sum_add;
    end else if (phase_q == PH_SEL && len_ok) begin
      phase_d = PH_PAYLOAD;
      left_d  = rx_byte_i;
      count_d = '0;
      sum_d   = sum_add;
    end else if (phase_q == PH_PAYLOAD && left_q != 8'd0) begin
      left_d = left_q - 8'd1;
      sum_d  = sum_add;
      // count saturates once the head store is full
      if (count_q < sfd_pkg::HeadCntW'(sfd_pkg::HeadDepth)) begin
        head_we = 1'b1;
        count_d = count_q + sfd_pkg::HeadCntW'(1);
      end
      if (left_q == 8'd1) begin
        phase_d = PH_CHECK;
      end
    end else begin
      phase_d = PH_IDLE;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      sel_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      sel_q   <= sel_d;
    end
  end

  // first payload bytes
  always_ff @(posedge clk_i) begin
    if (accept_i && head_we) begin
      head_q[count_q[sfd_pkg::HeadIdxW-1:0]] <= rx_byte_i;
    end
  end

  // frame result at the checksum byte
  logic [31:0]                  word0, word1;
  logic [sfd_pkg::HeadCntW-1:0] need;
  logic                         known;
  sfd_pkg::status_e             status;

  assign word0 = {head_q[3], head_q[2], head_q[1], head_q[0]};
  assign word1 = {head_q[7], head_q[6], head_q[5], head_q[4]};

  always_comb begin
    known = 1'b1;
    need  = '0;
    case (sel_q)
      sfd_pkg::SEL_NONE: need = '0;
      sfd_pkg::SEL_SPEED, sfd_pkg::SEL_DISTANCE, sfd_pkg::SEL_PRESSURE:
        need = sfd_pkg::HeadCntW'(4);
      sfd_pkg::SEL_SPD_DIST, sfd_pkg::SEL_CUR_PRES:
        need = sfd_pkg::HeadCntW'(8);
      default: known = 1'b0;
    endcase

    if (rx_byte_i != sum_q)  status = sfd_pkg::STATUS_CHECKSUM;
    else if (!known)         status = sfd_pkg::STATUS_UNKNOWN;
    else if (count_q < need) status = sfd_pkg::STATUS_SHORT;
    else                     status = sfd_pkg::STATUS_OK;

    res_o              = '0;
    res_o.frame_status = status;
    res_o.selector     = sel_q;
    if (status == sfd_pkg::STATUS_OK) begin
      case (sel_q)
        sfd_pkg::SEL_SPEED: begin
          res_o.speed_valid = 1'b1;
          res_o.speed_bits  = word0;
        end
        sfd_pkg::SEL_DISTANCE: begin
          res_o.distance_valid = 1'b1;
          res_o.distance_bits  = word0;
        end
        sfd_pkg::SEL_PRESSURE: begin
          res_o.pressure_valid = 1'b1;
          res_o.pressure_bits  = word0;
        end
        sfd_pkg::SEL_SPD_DIST: begin
          res_o.speed_valid            = 1'b1;
          res_o.speed_bits             = word0;
          res_o.distance_valid         = 1'b1;
          res_o.distance_bits          = word1;
          res_o.distance_in_hundredths = 1'b1;
        end
        sfd_pkg::SEL_CUR_PRES: begin
          res_o.current_valid  = 1'b1;
          res_o.current_bits   = word0;
          res_o.pressure_valid = 1'b1;
          res_o.pressure_bits  = word1;
        end
        default: ;
      endcase
    end
  end

  assign res_valid_o = accept_i && phase_q == PH_CHECK;

endmodule

[rtl/sensor_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_unit
// Serial frame deframer with additive checksum and sensor word extraction.
// ----------------------------------------------------------------------------
// The unit takes one received byte per clock cycle unless stalled and emits
// one result transaction, registered, when the checksum byte of a frame is
// taken. Parsing is a single registered pass per byte (compare, 8-bit add,
// register write), so the input side sustains one byte every cycle unless
// stalled. The results go through an output register backed by a one-entry
// skid register: input stalls only when both hold results the consumer has
// not yet taken. Float words are delivered raw; for selector 8 the distance
// word is flagged as counted in hundredths and the divide is left to software.
module sensor_frame_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  selector_o,
  output logic        speed_valid_o,
  output logic [31:0] speed_bits_o,
  output logic        distance_valid_o,
  output logic [31:0] distance_bits_o,
  output logic        distance_in_hundredths_o,
  output logic        pressure_valid_o,
  output logic [31:0] pressure_bits_o,
  output logic        current_valid_o,
  output logic [31:0] current_bits_o
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             res_valid;
  sfd_pkg::result_t res;

  logic             out_valid_q, out_valid_d;
  sfd_pkg::result_t out_q, out_d;
  logic             skid_valid_q, skid_valid_d;
  sfd_pkg::result_t skid_q, skid_d;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  sfd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign push = res_valid;
  assign pop  = out_valid_q && out_ready_i;

  // output register with skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_d       = res;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // result ports
  assign out_valid_o              = out_valid_q;
  assign frame_status_o           = out_q.frame_status;
  assign selector_o               = out_q.selector;
  assign speed_valid_o            = out_q.speed_valid;
  assign speed_bits_o             = out_q.speed_bits;
  assign distance_valid_o         = out_q.distance_valid;
  assign distance_bits_o          = out_q.distance_bits;
  assign distance_in_hundredths_o = out_q.distance_in_hundredths;
  assign pressure_valid_o         = out_q.pressure_valid;
  assign pressure_bits_o          = out_q.pressure_bits;
  assign current_valid_o          = out_q.current_valid;
  assign current_bits_o           = out_q.current_bits;

  // skid entry is only used behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // a result arriving behind a stalled output must land in the skid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && push) |=> skid_valid_q)
    else $error("result lost behind stalled output");

  // failed frames carry no sensor words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != sfd_pkg::STATUS_OK) |->
      !(speed_valid_o || distance_valid_o || pressure_valid_o ||
        current_valid_o || distance_in_hundredths_o))
    else $error("valid flag set on failed frame");

  // hundredths flag only with a selector 8 distance word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && distance_in_hundredths_o) |->
      (selector_o == sfd_pkg::SEL_SPD_DIST && distance_valid_o && speed_valid_o))
    else $error("hundredths flag without selector 8 distance");

endmodule
